FILE: src/mfqs_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
`default_nettype none

package mfqs_pkg;

   localparam int NUM_LEVELS = 3;
   localparam int LEVEL_W    = 2;
   localparam int ID_W       = 8;
   localparam int TIME_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int ENTRY_W    = ID_W + TIME_W;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [ID_W-1:0]    id_type;

   localparam level_type LEVEL_HIGH = 2'd0;
   localparam level_type LEVEL_MID  = 2'd1;
   localparam level_type LEVEL_LOW  = 2'd2;

   localparam time_type QUANTUM_HIGH_RESET = 16'd2;
   localparam time_type QUANTUM_MID_RESET  = 16'd4;
   localparam time_type QUANTUM_LOW_RESET  = 16'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUANTUM_HIGH = 2'd0,
      CSR_QUANTUM_MID  = 2'd1,
      CSR_QUANTUM_LOW  = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_ADMIT = 1'b0,
      OP_RUN   = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ADMITTED = 3'd0,
      STATUS_DROPPED  = 3'd1,
      STATUS_FINISHED = 3'd2,
      STATUS_DEMOTED  = 3'd3,
      STATUS_IDLE     = 3'd4
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      time_type q_high;
      time_type q_mid;
      time_type q_low;
   } quanta_type;

endpackage

`default_nettype wire

FILE: src/mfqs_if.sv
// Valid/ready channel interfaces: request, response and register write.
`default_nettype none

interface mfqs_req_if import mfqs_pkg::*;;
   logic     valid;
   logic     ready;
   logic     opcode;
   id_type   proc_id;
   time_type duration;
   modport source (output valid, output opcode, output proc_id, output duration, input ready);
   modport sink   (input valid, input opcode, input proc_id, input duration, output ready);
endinterface

interface mfqs_rsp_if import mfqs_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   id_type              out_id;
   level_type           level;
   time_type            remaining_after;
   modport source (output valid, output status, output out_id, output level,
                   output remaining_after, input ready);
   modport sink   (input valid, input status, input out_id, input level,
                   input remaining_after, output ready);
endinterface

interface mfqs_csr_if import mfqs_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   time_type             data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/mfqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mfqs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: src/mfqs_csr.sv
// Quantum register file behind the register write channel.
`default_nettype none

module mfqs_csr import mfqs_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   mfqs_csr_if.sink   csr_chan,
   output quanta_type quanta
);

   quanta_type quanta_ff, quanta_in;

   assign csr_chan.ready = 1'b1;
   assign quanta         = quanta_ff;

   always_comb begin
      quanta_in = quanta_ff;
      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_QUANTUM_HIGH: quanta_in.q_high = csr_chan.data;
            CSR_QUANTUM_MID:  quanta_in.q_mid  = csr_chan.data;
            CSR_QUANTUM_LOW:  quanta_in.q_low  = csr_chan.data;
            default:          quanta_in = quanta_ff;   // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quanta_ff <= '{q_high: QUANTUM_HIGH_RESET, q_mid: QUANTUM_MID_RESET,
                        q_low: QUANTUM_LOW_RESET};
      end else begin
         quanta_ff <= quanta_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/multilevel_feedback_queue_scheduler_core.sv
// Top level of the three-level feedback queue scheduler.
//
//  channel   dir  beat carries                                   taken when
//  req_chan  in   opcode, proc_id, duration                      valid && ready
//  rsp_chan  out  status, out_id, level, remaining_after         valid && ready
//  csr_chan  in   index (quantum high/mid/low), data             valid && ready
//
// Each request passes through an accept cycle that issues the queue memory
// read at the head of the chosen level, and an execute cycle that consumes the
// registered read data, writes back the pushed entry and loads the response.
// The execute cycle waits while the previous response is still not taken, so one
// request can be accepted behind a pending response. Reset is synchronous and
// resets pointers, counts and quanta; the queue memory is never cleared, since
// the counts keep reads away from unwritten entries. Register writes are taken
// in any cycle.
`default_nettype none

module multilevel_feedback_queue_scheduler_core import mfqs_pkg::*; #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   mfqs_req_if.sink   req_chan,
   mfqs_rsp_if.source rsp_chan,
   mfqs_csr_if.sink   csr_chan
);

   localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int RAM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);

   localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] BASE_MID = ADDR_W'(QUEUE_DEPTH);
   localparam logic [ADDR_W-1:0] BASE_LOW = ADDR_W'(2 * QUEUE_DEPTH);

   // Step a circular index, wrapping at the last slot.
   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_LAST) ? '0 : idx + 1'b1;
   endfunction

   // Map a level and slot to a flat memory address.
   function automatic logic [ADDR_W-1:0] addr_of(input level_type lv,
                                                 input logic [IDX_W-1:0] idx);
      logic [ADDR_W-1:0] base;
      case (lv)
         LEVEL_HIGH: base = '0;
         LEVEL_MID:  base = BASE_MID;
         default:    base = BASE_LOW;
      endcase
      return base + ADDR_W'(idx);
   endfunction

   // ---------------------------------------------------------------- quanta
   quanta_type quanta;

   mfqs_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .quanta   (quanta)
   );

   // ----------------------------------------------------------- queue state
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff  [NUM_LEVELS];
   logic [IDX_W-1:0]  head_in  [NUM_LEVELS];
   logic [IDX_W-1:0]  tail_ff  [NUM_LEVELS];
   logic [IDX_W-1:0]  tail_in  [NUM_LEVELS];
   logic [CNT_W-1:0]  count_ff [NUM_LEVELS];
   logic [CNT_W-1:0]  count_in [NUM_LEVELS];

   // Request held for the execute cycle.
   opcode_type op_ff;
   id_type     id_ff;
   time_type   dur_ff;
   level_type  lv_ff;
   logic       empty_ff;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   id_type     rsp_id_ff;
   level_type  rsp_level_ff;
   time_type   rsp_rem_ff;

   // Memory port.
   logic                 ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]    ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_wr_data, ram_rd_data;

   mfqs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------- accept cycle
   logic      accept, fire, all_empty;
   level_type pick_lv;

   assign accept    = req_chan.valid && req_chan.ready;
   assign all_empty = (count_ff[0] == '0) && (count_ff[1] == '0) && (count_ff[2] == '0);

   // Pick the highest non-empty level.
   always_comb begin
      if (count_ff[0] != '0) begin
         pick_lv = LEVEL_HIGH;
      end else if (count_ff[1] != '0) begin
         pick_lv = LEVEL_MID;
      end else begin
         pick_lv = LEVEL_LOW;
      end
   end

   // Issue the head read for a run beat; data lands for the execute cycle.
   assign ram_rd_en   = accept && (opcode_type'(req_chan.opcode) == OP_RUN) && !all_empty;
   assign ram_rd_addr = addr_of(pick_lv, head_ff[pick_lv]);

   // ------------------------------------------------------ state machine
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (fire)   state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      fire           = 1'b0;
      case (state_ff)
         ST_IDLE: req_chan.ready = 1'b1;
         ST_EXEC: fire = !rsp_valid_ff || rsp_chan.ready;   // hold while response waits
         default: begin
            req_chan.ready = 1'b0;
            fire           = 1'b0;
         end
      endcase
   end

   // ----------------------------------------------------- execute cycle
   time_type   entry_rem, quantum, rem_left;
   id_type     entry_id;
   level_type  dest_lv, push_lv;
   logic       push, pop, admit_full;
   status_type res_status;
   id_type     res_id;
   level_type  res_level;
   time_type   res_rem;

   assign entry_rem  = ram_rd_data[TIME_W-1:0];
   assign entry_id   = ram_rd_data[ENTRY_W-1:TIME_W];
   assign rem_left   = entry_rem - quantum;
   assign admit_full = (count_ff[0] == CNT_FULL);

   always_comb begin
      case (lv_ff)
         LEVEL_HIGH: quantum = quanta.q_high;
         LEVEL_MID:  quantum = quanta.q_mid;
         default:    quantum = quanta.q_low;
      endcase
   end

   // Demote one level; the lowest level requeues at its own tail, and a full
   // target sends the process back to the level it ran in.
   always_comb begin
      dest_lv = (lv_ff == LEVEL_LOW) ? lv_ff : lv_ff + 2'd1;
      if ((dest_lv != lv_ff) && (count_ff[dest_lv] == CNT_FULL)) begin
         dest_lv = lv_ff;
      end
   end

   always_comb begin
      push        = 1'b0;
      pop         = 1'b0;
      push_lv     = LEVEL_HIGH;
      ram_wr_data = {id_ff, dur_ff};
      res_status  = STATUS_IDLE;
      res_id      = '0;
      res_level   = LEVEL_HIGH;
      res_rem     = '0;
      if (op_ff == OP_ADMIT) begin
         res_id  = id_ff;
         res_rem = dur_ff;
         if (admit_full) begin
            res_status = STATUS_DROPPED;
         end else begin
            res_status = STATUS_ADMITTED;
            push       = 1'b1;
         end
      end else if (!empty_ff) begin
         pop       = 1'b1;
         res_id    = entry_id;
         res_level = lv_ff;
         if (entry_rem <= quantum) begin
            res_status = STATUS_FINISHED;
         end else begin
            res_status  = STATUS_DEMOTED;
            res_rem     = rem_left;
            push        = 1'b1;
            push_lv     = dest_lv;
            ram_wr_data = {entry_id, rem_left};
         end
      end
   end

   assign ram_wr_en   = fire && push;
   assign ram_wr_addr = addr_of(push_lv, tail_ff[push_lv]);

   // Advance pointers and counts of every level touched.
   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         logic do_push, do_pop;
         do_push = fire && push && (push_lv == LEVEL_W'(l));
         do_pop  = fire && pop && (lv_ff == LEVEL_W'(l));
         head_in[l]  = do_pop  ? wrap_next(head_ff[l]) : head_ff[l];
         tail_in[l]  = do_push ? wrap_next(tail_ff[l]) : tail_ff[l];
         count_in[l] = count_ff[l] + CNT_W'(do_push) - CNT_W'(do_pop);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l]  <= head_in[l];
            tail_ff[l]  <= tail_in[l];
            count_ff[l] <= count_in[l];
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= opcode_type'(req_chan.opcode);
         id_ff    <= req_chan.proc_id;
         dur_ff   <= req_chan.duration;
         lv_ff    <= pick_lv;
         empty_ff <= all_empty;
      end
      if (fire) begin
         rsp_status_ff <= res_status;
         rsp_id_ff     <= res_id;
         rsp_level_ff  <= res_level;
         rsp_rem_ff    <= res_rem;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.out_id          = rsp_id_ff;
   assign rsp_chan.level           = rsp_level_ff;
   assign rsp_chan.remaining_after = rsp_rem_ff;

   // ----------------------------------------------------------- assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff[0] <= CNT_FULL) && (count_ff[1] <= CNT_FULL) && (count_ff[2] <= CNT_FULL))
      else $error("queue occupancy above depth");

   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_rd_en && ram_wr_en))
      else $error("queue memory read and write in the same cycle");

   a_fire_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("execute cycle did not present a response");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (fire && pop) |-> (count_ff[lv_ff] != '0))
      else $error("pop from an empty level");

endmodule

`default_nettype wire

FILE: test/tb_multilevel_feedback_queue_scheduler_core.sv
// Testbench of the feedback queue scheduler core: directed table, random bursts, beat checks.
module tb_multilevel_feedback_queue_scheduler_core import mfqs_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH    = 64;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int TAIL_CYCLES    = 8;
   localparam int MAX_REPORTS    = 200;
   localparam int RESET_CYCLES   = 9;

   // One response beat as the scheduler should produce it.
   typedef struct packed {
      status_type status;
      id_type     out_id;
      level_type  level;
      time_type   remaining;
   } slot_outcome_type;

   // One waiting process in the bench's own copy of the level FIFOs.
   typedef struct packed {
      id_type   id;
      time_type remaining;
   } queue_entry_type;

   typedef enum logic { ROW_REQ, ROW_CSR } row_kind_type;

   // One row of the directed table. A pinned row carries its response typed in;
   // every other row is checked against the scheduler model.
   typedef struct {
      row_kind_type     kind;
      opcode_type       op;
      id_type           id;
      time_type         dur;
      csr_index_type    csr_idx;
      bit               pinned;
      slot_outcome_type outcome;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   mfqs_req_if req_chan ();
   mfqs_rsp_if rsp_chan ();
   mfqs_csr_if csr_chan ();

   multilevel_feedback_queue_scheduler_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Scheduler model: three circular FIFOs, their pointers and the quanta.
   // Only the checker process below touches these while the run is busy.
   // ---------------------------------------------------------------------------
   queue_entry_type  run_queue [NUM_LEVELS][QUEUE_DEPTH];
   int unsigned      q_head  [NUM_LEVELS];
   int unsigned      q_tail  [NUM_LEVELS];
   int unsigned      q_count [NUM_LEVELS];
   time_type         quantum_of [NUM_LEVELS];
   slot_outcome_type pending_outcomes [$];
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;

   // Stimulus controls shared by the sender and the response stall process.
   bit               calm    = 1'b0;
   bit               gaps_on = 1'b0;
   time_type         phase_quanta [NUM_LEVELS];
   bit               pinned_next;
   slot_outcome_type pinned_outcome;

   function automatic void enqueue_process(int lv, id_type id, time_type rem);
      run_queue[lv][q_tail[lv]] = '{id: id, remaining: rem};
      q_tail[lv] = (q_tail[lv] + 1) % QUEUE_DEPTH;
      q_count[lv]++;
   endfunction

   // Work out the response to one request beat and advance the model.
   function automatic slot_outcome_type schedule_slot(opcode_type op, id_type id,
                                                      time_type dur);
      slot_outcome_type res;
      queue_entry_type  ent;
      int               lv;
      int               dest;
      res = '{status: STATUS_IDLE, out_id: '0, level: LEVEL_HIGH, remaining: '0};
      lv  = 0;
      if (op == OP_ADMIT) begin
         // Admit or drop both echo id and duration at the top level.
         res.out_id    = id;
         res.remaining = dur;
         if (q_count[LEVEL_HIGH] >= QUEUE_DEPTH) begin
            res.status = STATUS_DROPPED;
         end else begin
            enqueue_process(LEVEL_HIGH, id, dur);
            res.status = STATUS_ADMITTED;
         end
      end else begin
         while (lv < NUM_LEVELS && q_count[lv] == 0) lv++;
         if (lv < NUM_LEVELS) begin
            ent        = run_queue[lv][q_head[lv]];
            q_head[lv] = (q_head[lv] + 1) % QUEUE_DEPTH;
            q_count[lv]--;
            res.out_id = ent.id;
            res.level  = level_type'(lv);
            if (ent.remaining <= quantum_of[lv]) begin
               res.status = STATUS_FINISHED;
            end else begin
               // Demote one level; the lowest level and a full target requeue in place.
               dest = (lv + 1 < NUM_LEVELS) ? lv + 1 : lv;
               if (q_count[dest] >= QUEUE_DEPTH) dest = lv;
               res.remaining = ent.remaining - quantum_of[lv];
               enqueue_process(dest, ent.id, res.remaining);
               res.status = STATUS_DEMOTED;
            end
         end
      end
      return res;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: rsp %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Checker: at every edge, apply register writes, match response beats against
   // the oldest expectation, then predict the request beat taken at this edge.
   // Doing all three in one process keeps the queue order independent of the
   // simulator's scheduling.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      slot_outcome_type want;
      slot_outcome_type predicted;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("** multilevel_feedback_queue_scheduler_core: FAILED **");
         $finish;
      end else if (reset) begin
         // Clear pointers and counts, load reset quanta, drop anything queued.
         for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            q_head[lv]  = 0;
            q_tail[lv]  = 0;
            q_count[lv] = 0;
         end
         quantum_of[LEVEL_HIGH] = QUANTUM_HIGH_RESET;
         quantum_of[LEVEL_MID]  = QUANTUM_MID_RESET;
         quantum_of[LEVEL_LOW]  = QUANTUM_LOW_RESET;
         pending_outcomes.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_QUANTUM_HIGH: quantum_of[LEVEL_HIGH] = csr_chan.data;
               CSR_QUANTUM_MID:  quantum_of[LEVEL_MID]  = csr_chan.data;
               CSR_QUANTUM_LOW:  quantum_of[LEVEL_LOW]  = csr_chan.data;
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_outcomes.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"%0t: rsp beat with nothing expected, expected none, ",
                            "got status=%0d id=%0d level=%0d remaining=%0d"},
                           $time, rsp_chan.status, rsp_chan.out_id, rsp_chan.level,
                           rsp_chan.remaining_after);
            end else begin
               want = pending_outcomes.pop_front();
               check_field("status", want.status, rsp_chan.status);
               check_field("out_id", want.out_id, rsp_chan.out_id);
               check_field("level", want.level, rsp_chan.level);
               check_field("remaining_after", want.remaining, rsp_chan.remaining_after);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            // Always advance the model; a pinned row overrides the expectation only.
            predicted = schedule_slot(opcode_type'(req_chan.opcode), req_chan.proc_id,
                                      req_chan.duration);
            pending_outcomes.push_back(pinned_next ? pinned_outcome : predicted);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response side: hold ready low in random bursts, leave quiet windows while
   // cycle_count[7:6] is 2'b11, and never stall once calm is set.
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned stall;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else if (!calm && cycle_count[7:6] != 2'b11 && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall = $urandom_range(0, 2);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------------

   // Present one request beat and hold it until taken; maybe idle first.
   task automatic send_request(opcode_type op, id_type id, time_type dur, bit pin,
                               slot_outcome_type outcome);
      if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.opcode   <= op;
      req_chan.proc_id  <= id;
      req_chan.duration <= dur;
      pinned_next       <= pin;
      pinned_outcome    <= outcome;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Stop sending and wait for every expected beat. The first edge lets the
   // checker record the beat taken at the current edge.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Write one quantum with the scheduler idle.
   task automatic write_quantum(csr_index_type idx, time_type value);
      settle();
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      phase_quanta[idx] = value;
   endtask

   // Durations clustered around the quanta, plus small and full-range values.
   function automatic time_type pick_duration();
      int v;
      case ($urandom_range(0, 4))
         0: v = $urandom_range(0, 15);
         1: v = phase_quanta[$urandom_range(0, NUM_LEVELS - 1)] + $urandom_range(0, 2) - 1;
         2: v = phase_quanta[LEVEL_HIGH] + phase_quanta[LEVEL_MID] + phase_quanta[LEVEL_LOW]
                + $urandom_range(0, 2) - 1;
         default: v = $urandom_range(0, 65535);
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return time_type'(v);
   endfunction

   // Send len beats of one opcode; long jobs survive the top two levels.
   task automatic send_burst(opcode_type op, int unsigned len, bit long_jobs);
      time_type dur;
      repeat (len) begin
         dur = long_jobs ? time_type'($urandom_range(256, 65535)) : pick_duration();
         send_request(op, id_type'($urandom_range(0, 255)), dur, 1'b0, '0);
      end
   endtask

   // Random bursts: short and long admit and run runs, mixed beats, and an
   // occasional full drain.
   task automatic random_phase(int unsigned n);
      int unsigned done;
      int unsigned len;
      int unsigned pick;
      done = 0;
      while (done < n) begin
         pick    = $urandom_range(0, 99);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (pick < 3) begin
            settle();
            len = 0;
         end else if (pick < 38) begin
            len = $urandom_range(1, 8);
            send_burst(OP_ADMIT, len, 1'b0);
         end else if (pick < 73) begin
            len = $urandom_range(1, 8);
            send_burst(OP_RUN, len, 1'b0);
         end else if (pick < 83) begin
            len = $urandom_range(40, 70);
            send_burst(OP_ADMIT, len, 1'b0);
         end else if (pick < 90) begin
            len = $urandom_range(40, 130);
            send_burst(OP_RUN, len, 1'b0);
         end else begin
            len = $urandom_range(1, 10);
            repeat (len) send_burst(opcode_type'($urandom_range(0, 1)), 1, 1'b0);
         end
         done += len;
      end
   endtask

   task automatic run_phase(time_type q_hi, time_type q_md, time_type q_lo, int unsigned n);
      write_quantum(CSR_QUANTUM_HIGH, q_hi);
      write_quantum(CSR_QUANTUM_MID, q_md);
      write_quantum(CSR_QUANTUM_LOW, q_lo);
      random_phase(n);
   endtask

   function automatic plan_row_type req_row(opcode_type op, id_type id, time_type dur);
      plan_row_type r;
      r = '{kind: ROW_REQ, op: op, id: id, dur: dur, csr_idx: CSR_QUANTUM_HIGH,
            pinned: 1'b0, outcome: '0};
      return r;
   endfunction

   function automatic plan_row_type pinned_row(opcode_type op, id_type id, time_type dur,
                                               status_type st, id_type oid, level_type lv,
                                               time_type rem);
      plan_row_type r;
      r         = req_row(op, id, dur);
      r.pinned  = 1'b1;
      r.outcome = '{status: st, out_id: oid, level: lv, remaining: rem};
      return r;
   endfunction

   function automatic plan_row_type csr_row(csr_index_type idx, time_type value);
      plan_row_type r;
      r         = req_row(OP_ADMIT, '0, value);
      r.kind    = ROW_CSR;
      r.csr_idx = idx;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------------
   initial begin
      plan_row_type plan [$];
      int unsigned  backlog;

      reset = 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.opcode   <= OP_ADMIT;
      req_chan.proc_id  <= '0;
      req_chan.duration <= '0;
      csr_chan.valid    <= 1'b0;
      csr_chan.index    <= CSR_QUANTUM_HIGH;
      csr_chan.data     <= '0;
      pinned_next       <= 1'b0;
      pinned_outcome    <= '0;
      phase_quanta[LEVEL_HIGH] = QUANTUM_HIGH_RESET;
      phase_quanta[LEVEL_MID]  = QUANTUM_MID_RESET;
      phase_quanta[LEVEL_LOW]  = QUANTUM_LOW_RESET;

      // Directed table, starting from reset quanta 2/4/8.
      // Run with every queue empty reports idle; run fields are don't-care.
      plan.push_back(pinned_row(OP_RUN, 8'hC3, 16'h1234, STATUS_IDLE, '0, LEVEL_HIGH, '0));
      // Admit the field extremes and two jobs at and just over the top quantum.
      plan.push_back(pinned_row(OP_ADMIT, 8'h00, 16'h0000, STATUS_ADMITTED, 8'h00, LEVEL_HIGH,
                                16'h0000));
      plan.push_back(pinned_row(OP_ADMIT, 8'hFF, 16'hFFFF, STATUS_ADMITTED, 8'hFF, LEVEL_HIGH,
                                16'hFFFF));
      plan.push_back(pinned_row(OP_ADMIT, 8'h5A, 16'd2, STATUS_ADMITTED, 8'h5A, LEVEL_HIGH,
                                16'd2));
      plan.push_back(pinned_row(OP_ADMIT, 8'hA5, 16'd3, STATUS_ADMITTED, 8'hA5, LEVEL_HIGH,
                                16'd3));
      // Zero remaining finishes, the big job demotes, equal-to-quantum finishes, one over demotes.
      plan.push_back(pinned_row(OP_RUN, 8'h00, 16'h0000, STATUS_FINISHED, 8'h00, LEVEL_HIGH,
                                16'h0000));
      plan.push_back(pinned_row(OP_RUN, 8'hFF, 16'hFFFF, STATUS_DEMOTED, 8'hFF, LEVEL_HIGH,
                                16'hFFFD));
      plan.push_back(pinned_row(OP_RUN, 8'h3C, 16'h8001, STATUS_FINISHED, 8'h5A, LEVEL_HIGH,
                                16'h0000));
      plan.push_back(pinned_row(OP_RUN, 8'h00, 16'h0000, STATUS_DEMOTED, 8'hA5, LEVEL_HIGH,
                                16'd1));
      // Middle level demotes to the lowest, finishes; lowest requeues at its own tail.
      plan.push_back(req_row(OP_RUN, 8'h00, 16'h0000));
      plan.push_back(req_row(OP_RUN, 8'hFF, 16'hFFFF));
      plan.push_back(req_row(OP_RUN, 8'h00, 16'h0000));
      // Zero quantum at the top: zero remaining finishes, anything else moves down whole.
      plan.push_back(csr_row(CSR_QUANTUM_HIGH, 16'h0000));
      plan.push_back(pinned_row(OP_ADMIT, 8'h11, 16'd0, STATUS_ADMITTED, 8'h11, LEVEL_HIGH,
                                16'd0));
      plan.push_back(pinned_row(OP_ADMIT, 8'h22, 16'd5, STATUS_ADMITTED, 8'h22, LEVEL_HIGH,
                                16'd5));
      plan.push_back(pinned_row(OP_RUN, 8'h00, 16'h0000, STATUS_FINISHED, 8'h11, LEVEL_HIGH,
                                16'd0));
      plan.push_back(pinned_row(OP_RUN, 8'h00, 16'h0000, STATUS_DEMOTED, 8'h22, LEVEL_HIGH,
                                16'd5));
      plan.push_back(csr_row(CSR_QUANTUM_MID, 16'h0000));
      plan.push_back(csr_row(CSR_QUANTUM_LOW, 16'h0000));
      plan.push_back(req_row(OP_RUN, 8'h00, 16'h0000));
      plan.push_back(req_row(OP_RUN, 8'h00, 16'h0000));
      plan.push_back(req_row(OP_RUN, 8'h00, 16'h0000));
      // Largest quanta finish whatever is left, then idle again.
      plan.push_back(csr_row(CSR_QUANTUM_HIGH, 16'hFFFF));
      plan.push_back(csr_row(CSR_QUANTUM_MID, 16'hFFFF));
      plan.push_back(csr_row(CSR_QUANTUM_LOW, 16'hFFFF));
      plan.push_back(req_row(OP_RUN, 8'h00, 16'h0000));
      plan.push_back(req_row(OP_RUN, 8'h00, 16'h0000));
      plan.push_back(pinned_row(OP_RUN, 8'hFF, 16'hFFFF, STATUS_IDLE, '0, LEVEL_HIGH, '0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      gaps_on = 1'b1;
      foreach (plan[k]) begin
         if (plan[k].kind == ROW_CSR)
            write_quantum(plan[k].csr_idx, plan[k].dur);
         else
            send_request(plan[k].op, plan[k].id, plan[k].dur, plan[k].pinned, plan[k].outcome);
      end

      // Random phases across several quantum settings, extremes included.
      run_phase(QUANTUM_HIGH_RESET, QUANTUM_MID_RESET, QUANTUM_LOW_RESET, 250);
      run_phase(16'd1, 16'd1, 16'd1, 250);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 200);
      run_phase(16'd0, 16'd0, 16'd0, 150);
      run_phase(16'd3, 16'hFFFF, 16'd1, 250);

      // Empty every level with the largest quanta: each run but the last finishes a job.
      write_quantum(CSR_QUANTUM_HIGH, 16'hFFFF);
      write_quantum(CSR_QUANTUM_MID, 16'hFFFF);
      write_quantum(CSR_QUANTUM_LOW, 16'hFFFF);
      settle();
      backlog = q_count[LEVEL_HIGH] + q_count[LEVEL_MID] + q_count[LEVEL_LOW];
      send_burst(OP_RUN, backlog + 1, 1'b0);

      // Flood with small quanta: overflow the top level, fill the lowest level,
      // then fill the middle one so that demotions meet a full target at both
      // the middle and the lowest level and requeue in place.
      write_quantum(CSR_QUANTUM_HIGH, time_type'($urandom_range(1, 20)));
      write_quantum(CSR_QUANTUM_MID, time_type'($urandom_range(1, 20)));
      write_quantum(CSR_QUANTUM_LOW, time_type'($urandom_range(1, 20)));
      send_burst(OP_ADMIT, QUEUE_DEPTH + 2, 1'b1);
      send_burst(OP_RUN, 2 * QUEUE_DEPTH + 2, 1'b0);
      send_burst(OP_ADMIT, QUEUE_DEPTH, 1'b1);
      send_burst(OP_RUN, QUEUE_DEPTH + 1, 1'b0);
      send_burst(OP_ADMIT, 4, 1'b1);
      send_burst(OP_RUN, 108, 1'b0);

      // Random full-range quanta; the last stretch runs without any idling.
      run_phase(time_type'($urandom_range(0, 65535)), time_type'($urandom_range(0, 65535)),
                time_type'($urandom_range(0, 65535)), 200);
      calm = 1'b1;
      random_phase(200);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("** multilevel_feedback_queue_scheduler_core: PASSED **");
      end else begin
         if (pending_outcomes.size() != 0)
            $display("%0t: %0d expected rsp beats never arrived", $time,
                     pending_outcomes.size());
         $display("** multilevel_feedback_queue_scheduler_core: FAILED **");
      end
      $finish;
   end

endmodule
